>>> hdl/tod_pkg.sv
// time-of-day counter package: action codes, day constants, queue item type
// and the constants of the constant-divisor fold; no dependencies
`timescale 1ns / 1ps

package tod_pkg;

   typedef enum logic [1:0] {
      ACT_CHECKED_SET = 2'd0,
      ACT_NORM_SET    = 2'd1,
      ACT_SHIFT       = 2'd2,
      ACT_DIFF        = 2'd3
   } action_type;

   localparam int DAY_BITS  = 17;
   localparam int DIFF_BITS = 18;

   localparam logic [DAY_BITS-1:0]  SECS_PER_DAY  = 17'd86400;
   localparam logic [DIFF_BITS-1:0] SECS_PER_DAY_W = 18'd86400;
   localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
   localparam logic [31:0] SECS_PER_MIN  = 32'd60;
   localparam logic [14:0] MAX_HOUR      = 15'd23;
   localparam logic [14:0] MAX_MINSEC    = 15'd59;

   // 86400 = 128 * 675; the offset is a multiple of 86400 that lifts any
   // 32-bit signed value into the non-negative 33-bit range
   localparam logic [31:0] FOLD_OFFSET = 32'd2147558400;
   localparam logic [25:0] FOLD_RECIP  = 26'd50903316;   // floor(2^35 / 675)
   localparam int          FOLD_SHIFT  = 35;
   localparam logic [25:0] FOLD_DIV    = 26'd675;

   // exact reciprocals for splitting the seconds of the day
   localparam logic [17:0] RECIP_60_DAY  = 18'd139811;  // ceil(2^23 / 60)
   localparam int          SHIFT_60_DAY  = 23;
   localparam logic [11:0] RECIP_60_MIN  = 12'd2185;    // ceil(2^17 / 60)
   localparam int          SHIFT_60_MIN  = 17;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   typedef struct packed {
      action_type          act;
      logic                bad;
      logic [DAY_BITS-1:0] folded;
   } item_type;

endpackage

>>> hdl/tod_front.sv
// front part: takes requests, checks the checked-set range and folds the
// given time or shift amount into the day; depends on tod_pkg
`timescale 1ns / 1ps

module tod_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tod_pkg::action_type   req_action,
   input  logic signed [15:0]    hours_in,
   input  logic signed [15:0]    minutes_in,
   input  logic signed [15:0]    seconds_in,
   input  logic signed [31:0]    amount,
   output logic                  push_valid,
   input  logic                  push_ready,
   output tod_pkg::item_type     push_item
);

   typedef struct packed {
      tod_pkg::action_type act;
      logic                bad;
      logic [32:0]         lifted;
   } stage_a_type;

   typedef struct packed {
      tod_pkg::action_type act;
      logic                bad;
      logic [25:0]         upper;
      logic [6:0]          lower;
      logic [50:0]         prod;
   } stage_b_type;

   typedef struct packed {
      tod_pkg::action_type act;
      logic                bad;
      logic [25:0]         upper;
      logic [6:0]          lower;
      logic [25:0]         qmul;
   } stage_c_type;

   stage_a_type stage_a_ff, stage_a_in;
   stage_b_type stage_b_ff, stage_b_in;
   stage_c_type stage_c_ff, stage_c_in;
   logic        valid_a_ff, valid_a_in;
   logic        valid_b_ff, valid_b_in;
   logic        valid_c_ff, valid_c_in;
   logic        ready_a, ready_b, ready_c;
   logic [31:0] given;
   logic [31:0] chosen;
   logic        in_range;
   logic [15:0] quot;
   logic [25:0] rem_wide;
   logic [10:0] rem;
   logic [10:0] rem_fix;

   assign ready_c   = !valid_c_ff || push_ready;
   assign ready_b   = !valid_b_ff || ready_c;
   assign ready_a   = !valid_a_ff || ready_b;
   assign req_ready = ready_a;

   always_comb begin
      // modular arithmetic: the low 32 bits are the signed total
      given = {{16{hours_in[15]}}, hours_in} * tod_pkg::SECS_PER_HOUR
            + {{16{minutes_in[15]}}, minutes_in} * tod_pkg::SECS_PER_MIN
            + {{16{seconds_in[15]}}, seconds_in};
      chosen   = (req_action == tod_pkg::ACT_SHIFT) ? amount : given;
      in_range = !hours_in[15] && (hours_in[14:0] <= tod_pkg::MAX_HOUR) &&
                 !minutes_in[15] && (minutes_in[14:0] <= tod_pkg::MAX_MINSEC) &&
                 !seconds_in[15] && (seconds_in[14:0] <= tod_pkg::MAX_MINSEC);

      stage_a_in = stage_a_ff;
      valid_a_in = valid_a_ff;
      if (ready_a) begin
         valid_a_in        = req_valid;
         stage_a_in.act    = req_action;
         stage_a_in.bad    = (req_action == tod_pkg::ACT_CHECKED_SET) && !in_range;
         stage_a_in.lifted = {chosen[31], chosen} + {1'b0, tod_pkg::FOLD_OFFSET};
      end

      stage_b_in = stage_b_ff;
      valid_b_in = valid_b_ff;
      if (ready_b) begin
         valid_b_in       = valid_a_ff;
         stage_b_in.act   = stage_a_ff.act;
         stage_b_in.bad   = stage_a_ff.bad;
         stage_b_in.upper = stage_a_ff.lifted[32:7];
         stage_b_in.lower = stage_a_ff.lifted[6:0];
         stage_b_in.prod  = 51'(stage_a_ff.lifted[32:7]) * 51'(tod_pkg::FOLD_RECIP);
      end

      // quotient estimate is exact or one short
      quot       = stage_b_ff.prod[50:tod_pkg::FOLD_SHIFT];
      stage_c_in = stage_c_ff;
      valid_c_in = valid_c_ff;
      if (ready_c) begin
         valid_c_in       = valid_b_ff;
         stage_c_in.act   = stage_b_ff.act;
         stage_c_in.bad   = stage_b_ff.bad;
         stage_c_in.upper = stage_b_ff.upper;
         stage_c_in.lower = stage_b_ff.lower;
         stage_c_in.qmul  = 26'(quot) * tod_pkg::FOLD_DIV;
      end

      rem_wide = stage_c_ff.upper - stage_c_ff.qmul;
      rem      = rem_wide[10:0];
      rem_fix  = (rem >= 11'(tod_pkg::FOLD_DIV)) ? rem - 11'(tod_pkg::FOLD_DIV) : rem;
   end

   assign push_valid       = valid_c_ff;
   assign push_item.act    = stage_c_ff.act;
   assign push_item.bad    = stage_c_ff.bad;
   assign push_item.folded = {rem_fix[9:0], stage_c_ff.lower};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
         valid_c_ff <= valid_c_in;
      end
      stage_a_ff <= stage_a_in;
      stage_b_ff <= stage_b_in;
      stage_c_ff <= stage_c_in;
   end

endmodule

>>> hdl/tod_queue.sv
// short register queue between the front and back parts of the
// time-of-day counter; depends on tod_pkg
`timescale 1ns / 1ps

module tod_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tod_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output tod_pkg::item_type pop_item
);

   tod_pkg::item_type                     slot_ff [tod_pkg::QUEUE_DEPTH];
   tod_pkg::item_type                     slot_in [tod_pkg::QUEUE_DEPTH];
   logic [tod_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tod_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tod_pkg::QUEUE_CNT_BITS-1:0]    count_ff, count_in;
   logic                                  do_push, do_pop;

   assign push_ready = (count_ff != tod_pkg::QUEUE_CNT_BITS'(tod_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         slot_in[wr_ptr_ff] = push_item;
         wr_ptr_in          = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      slot_ff <= slot_in;
   end

endmodule

>>> hdl/tod_back.sv
// back part: holds the time as seconds of the day, applies each action and
// splits the result into hours, minutes and seconds; depends on tod_pkg
`timescale 1ns / 1ps

module tod_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  tod_pkg::item_type pop_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [4:0]        hours_out,
   output logic [5:0]        minutes_out,
   output logic [5:0]        seconds_out,
   output logic              invalid_time,
   output logic [17:0]       difference
);

   typedef struct packed {
      logic [16:0] total;
      logic        bad;
      logic [17:0] diff;
   } stage_e_type;

   typedef struct packed {
      logic [16:0] total;
      logic [10:0] mtot;
      logic        bad;
      logic [17:0] diff;
   } stage_f_type;

   typedef struct packed {
      logic [10:0] mtot;
      logic [4:0]  hrs;
      logic [5:0]  sec;
      logic        bad;
      logic [17:0] diff;
   } stage_g_type;

   typedef struct packed {
      logic [4:0]  hrs;
      logic [5:0]  mins;
      logic [5:0]  sec;
      logic        bad;
      logic [17:0] diff;
   } stage_h_type;

   logic [tod_pkg::DAY_BITS-1:0] time_ff, time_in;
   stage_e_type stage_e_ff, stage_e_in;
   stage_f_type stage_f_ff, stage_f_in;
   stage_g_type stage_g_ff, stage_g_in;
   stage_h_type stage_h_ff, stage_h_in;
   logic        valid_e_ff, valid_e_in;
   logic        valid_f_ff, valid_f_in;
   logic        valid_g_ff, valid_g_in;
   logic        valid_h_ff, valid_h_in;
   logic        ready_e, ready_f, ready_g, ready_h;
   logic        take;
   logic [17:0] sum;
   logic [17:0] diff_calc;
   logic [34:0] prod_day;
   logic [22:0] prod_min;
   logic [16:0] sec_wide;
   logic [10:0] min_wide;

   assign ready_h   = !valid_h_ff || rsp_ready;
   assign ready_g   = !valid_g_ff || ready_h;
   assign ready_f   = !valid_f_ff || ready_g;
   assign ready_e   = !valid_e_ff || ready_f;
   assign pop_ready = ready_e;
   assign take      = pop_valid && ready_e;

   always_comb begin
      // stored time update, one add and one wrap per item
      sum       = {1'b0, time_ff} + {1'b0, pop_item.folded};
      diff_calc = {1'b0, time_ff} - {1'b0, pop_item.folded};
      time_in   = time_ff;
      stage_e_in = stage_e_ff;
      valid_e_in = valid_e_ff;
      if (ready_e) begin
         valid_e_in = pop_valid;
      end
      if (take) begin
         stage_e_in.bad  = 1'b0;
         stage_e_in.diff = '0;
         case (pop_item.act)
            tod_pkg::ACT_CHECKED_SET: begin
               stage_e_in.bad = pop_item.bad;
               if (!pop_item.bad) begin
                  time_in = pop_item.folded;
               end
            end
            tod_pkg::ACT_NORM_SET: begin
               time_in = pop_item.folded;
            end
            tod_pkg::ACT_SHIFT: begin
               time_in = (sum >= tod_pkg::SECS_PER_DAY_W) ?
                         17'(sum - tod_pkg::SECS_PER_DAY_W) : sum[16:0];
            end
            tod_pkg::ACT_DIFF: begin
               stage_e_in.diff = diff_calc;
            end
            default: begin
               time_in = time_ff;
            end
         endcase
         stage_e_in.total = time_in;
      end

      // minutes of the day
      prod_day   = 35'(stage_e_ff.total) * 35'(tod_pkg::RECIP_60_DAY);
      stage_f_in = stage_f_ff;
      valid_f_in = valid_f_ff;
      if (ready_f) begin
         valid_f_in       = valid_e_ff;
         stage_f_in.total = stage_e_ff.total;
         stage_f_in.mtot  = prod_day[tod_pkg::SHIFT_60_DAY+10:tod_pkg::SHIFT_60_DAY];
         stage_f_in.bad   = stage_e_ff.bad;
         stage_f_in.diff  = stage_e_ff.diff;
      end

      // hours and seconds
      prod_min   = 23'(stage_f_ff.mtot) * 23'(tod_pkg::RECIP_60_MIN);
      sec_wide   = stage_f_ff.total - ((17'(stage_f_ff.mtot) << 6) -
                                       (17'(stage_f_ff.mtot) << 2));
      stage_g_in = stage_g_ff;
      valid_g_in = valid_g_ff;
      if (ready_g) begin
         valid_g_in      = valid_f_ff;
         stage_g_in.mtot = stage_f_ff.mtot;
         stage_g_in.hrs  = prod_min[tod_pkg::SHIFT_60_MIN+4:tod_pkg::SHIFT_60_MIN];
         stage_g_in.sec  = sec_wide[5:0];
         stage_g_in.bad  = stage_f_ff.bad;
         stage_g_in.diff = stage_f_ff.diff;
      end

      // minutes within the hour
      min_wide   = stage_g_ff.mtot - ((11'(stage_g_ff.hrs) << 6) -
                                      (11'(stage_g_ff.hrs) << 2));
      stage_h_in = stage_h_ff;
      valid_h_in = valid_h_ff;
      if (ready_h) begin
         valid_h_in      = valid_g_ff;
         stage_h_in.hrs  = stage_g_ff.hrs;
         stage_h_in.mins = min_wide[5:0];
         stage_h_in.sec  = stage_g_ff.sec;
         stage_h_in.bad  = stage_g_ff.bad;
         stage_h_in.diff = stage_g_ff.diff;
      end
   end

   assign rsp_valid    = valid_h_ff;
   assign hours_out    = stage_h_ff.hrs;
   assign minutes_out  = stage_h_ff.mins;
   assign seconds_out  = stage_h_ff.sec;
   assign invalid_time = stage_h_ff.bad;
   assign difference   = stage_h_ff.diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff    <= '0;
         valid_e_ff <= 1'b0;
         valid_f_ff <= 1'b0;
         valid_g_ff <= 1'b0;
         valid_h_ff <= 1'b0;
      end else begin
         time_ff    <= time_in;
         valid_e_ff <= valid_e_in;
         valid_f_ff <= valid_f_in;
         valid_g_ff <= valid_g_in;
         valid_h_ff <= valid_h_in;
      end
      stage_e_ff <= stage_e_in;
      stage_f_ff <= stage_f_in;
      stage_g_ff <= stage_g_in;
      stage_h_ff <= stage_h_in;
   end

endmodule

>>> hdl/time_of_day_clock_core.sv
// top level of the 24-hour time-of-day counter: front, queue and back
// depends on tod_pkg, tod_front, tod_queue and tod_back
`timescale 1ns / 1ps

// 24-hour time-of-day counter. Each request carries one action in req_tuser:
// checked set, normalized set, shift by signed seconds, or difference. Every
// request gives exactly one response with the time after the step, an
// invalid flag for a rejected checked set and, for the difference action,
// stored minus given seconds. One request is taken every clock cycle while
// the response side does not stall; the front folds the given time or shift
// amount into the day over three pipelined stages, and the only loop on the
// stored time is one add-and-wrap in the back, so the rate holds for any mix
// of actions. A request passes the front stages, the queue and the back
// stages to reach the response port; a four-entry queue and the back pipeline
// absorb response back-pressure. After reset the time is 00:00:00.
module time_of_day_clock_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // hours_in[15:0], minutes_in[31:16],
                                    // seconds_in[47:32], amount[79:48]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // hours_out[4:0], minutes_out[10:5],
                                    // seconds_out[16:11], invalid_time[17],
                                    // difference[35:18], zero pad[39:36]
);

   logic              push_valid, push_ready;
   logic              pop_valid, pop_ready;
   tod_pkg::item_type push_item, pop_item;
   logic [4:0]        hours_out;
   logic [5:0]        minutes_out;
   logic [5:0]        seconds_out;
   logic              invalid_time;
   logic [17:0]       difference;

   tod_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (tod_pkg::action_type'(req_tuser)),
      .hours_in   (req_tdata[15:0]),
      .minutes_in (req_tdata[31:16]),
      .seconds_in (req_tdata[47:32]),
      .amount     (req_tdata[79:48]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   tod_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   tod_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_item     (pop_item),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .hours_out    (hours_out),
      .minutes_out  (minutes_out),
      .seconds_out  (seconds_out),
      .invalid_time (invalid_time),
      .difference   (difference)
   );

   assign rsp_tdata = {4'b0000, difference, invalid_time, seconds_out,
                       minutes_out, hours_out};

`ifndef SYNTHESIS
   // the split always lands inside the day
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (hours_out <= 5'd23) && (minutes_out <= 6'd59) &&
                     (seconds_out <= 6'd59))
      else $error("time of day out of range");

   // a rejected set never carries a difference
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && invalid_time) |-> (difference == 18'd0))
      else $error("invalid flag with non-zero difference");

   // a difference stays within one day either way
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((!difference[17] && (difference <= 18'd86399)) ||
                      (difference[17] && (difference >= 18'd175745))))
      else $error("difference beyond one day");

   // nothing leaves the pipeline straight after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");
`endif

endmodule

>>> tb/time_of_day_clock_checker.sv
// checker for the time-of-day counter: watches both stream channels, predicts
// every response from the accepted requests and compares; depends on tod_pkg
`timescale 1ns / 1ps

module time_of_day_clock_checker
   import tod_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,   // hours_in[15:0], minutes_in[31:16],
                                    // seconds_in[47:32], amount[79:48]
   input  logic [1:0]  req_tuser,   // action[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // hours_out[4:0], minutes_out[10:5],
                                    // seconds_out[16:11], invalid_time[17],
                                    // difference[35:18], zero pad[39:36]
   output int          fail_count,
   output int          pending
);

   localparam longint MINUTE_LEN = 60;
   localparam longint HOUR_LEN   = 3600;
   localparam longint DAY_LEN    = 86400;
   localparam int     HOUR_TOP   = 23;
   localparam int     MINSEC_TOP = 59;

   // same layout as rsp_tdata[35:0], hours in the lowest bits
   typedef struct packed {
      logic [17:0] diff;
      logic        bad;
      logic [5:0]  secs;
      logic [5:0]  mins;
      logic [4:0]  hrs;
   } time_result_type;

   time_result_type expected_times[$];

   logic [4:0] clock_hours;
   logic [5:0] clock_minutes;
   logic [5:0] clock_seconds;

   function automatic longint wrap_into_day(input longint t);
      longint r;
      r = t % DAY_LEN;
      if (r < 0) begin
         r += DAY_LEN;
      end
      return r;
   endfunction

   function automatic longint seconds_of_day();
      return longint'(clock_hours) * HOUR_LEN + longint'(clock_minutes) * MINUTE_LEN
           + longint'(clock_seconds);
   endfunction

   function automatic void load_seconds_of_day(input longint t);
      longint u;
      u = wrap_into_day(t);
      clock_seconds = 6'(u % MINUTE_LEN);
      clock_minutes = 6'((u / MINUTE_LEN) % 60);
      clock_hours   = 5'((u / HOUR_LEN) % 24);
   endfunction

   // advances the predicted clock by one request and returns its response
   function automatic time_result_type next_time_of_day(input action_type act,
                                                        input logic signed [15:0] h_in,
                                                        input logic signed [15:0] m_in,
                                                        input logic signed [15:0] s_in,
                                                        input logic signed [31:0] amt);
      time_result_type res;
      longint given;
      longint delta;
      given = longint'(h_in) * HOUR_LEN + longint'(m_in) * MINUTE_LEN + longint'(s_in);
      delta = 0;
      res   = '0;
      case (act)
         ACT_CHECKED_SET: begin
            if (h_in < 0 || h_in > HOUR_TOP || m_in < 0 || m_in > MINSEC_TOP ||
                s_in < 0 || s_in > MINSEC_TOP) begin
               res.bad = 1'b1;
            end else begin
               clock_hours   = h_in[4:0];
               clock_minutes = m_in[5:0];
               clock_seconds = s_in[5:0];
            end
         end
         ACT_NORM_SET: begin
            load_seconds_of_day(given);
         end
         ACT_SHIFT: begin
            load_seconds_of_day(seconds_of_day() + longint'(amt));
         end
         default: begin
            delta    = seconds_of_day() - wrap_into_day(given);
            res.diff = delta[17:0];
         end
      endcase
      res.hrs  = clock_hours;
      res.mins = clock_minutes;
      res.secs = clock_seconds;
      return res;
   endfunction

   always @(posedge clock) begin
      time_result_type want;
      time_result_type got;
      if (reset) begin
         clock_hours   = '0;
         clock_minutes = '0;
         clock_seconds = '0;
         expected_times.delete();
         fail_count = 0;
         pending    = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            want = next_time_of_day(action_type'(req_tuser), req_tdata[15:0],
                                    req_tdata[31:16], req_tdata[47:32], req_tdata[79:48]);
            expected_times.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[35:0];
            if (expected_times.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: response with nothing outstanding: %0d:%0d:%0d bad=%0b diff=%0d",
                           $realtime, got.hrs, got.mins, got.secs, got.bad,
                           $signed(got.diff));
               end
            end else begin
               want = expected_times.pop_front();
               if (got.hrs !== want.hrs || got.mins !== want.mins ||
                   got.secs !== want.secs || got.bad !== want.bad ||
                   got.diff !== want.diff) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: mismatch, expected %0d:%0d:%0d bad=%0b diff=%0d",
                              $realtime, want.hrs, want.mins, want.secs, want.bad,
                              $signed(want.diff));
                     $display("           got      %0d:%0d:%0d bad=%0b diff=%0d",
                              got.hrs, got.mins, got.secs, got.bad, $signed(got.diff));
                  end
               end
            end
         end
         pending = expected_times.size();
      end
   end

endmodule

>>> tb/time_of_day_clock_core_tb.sv
// testbench top for the time-of-day counter: clock, reset, request and
// response drivers, verdict; depends on tod_pkg, core and checker
`timescale 1ns / 1ps

module time_of_day_clock_core_tb;
   import tod_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int PHASE_REQUESTS = 285;
   localparam int HOLD_CYCLES    = 400;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata  = '0;   // hours_in[15:0], minutes_in[31:16],
                                   // seconds_in[47:32], amount[79:48]
   logic [1:0]  req_tuser  = '0;   // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // hours_out[4:0], minutes_out[10:5],
                                   // seconds_out[16:11], invalid_time[17],
                                   // difference[35:18], zero pad[39:36]

   int fail_count;
   int pending_count;
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;
   int hold_left    = 0;
   bit hold_go      = 1'b0;
   bit hold_done    = 1'b0;
   int action_count[4];
   int cycles;

   always #2 clock = ~clock;

   time_of_day_clock_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   time_of_day_clock_checker time_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending_count)
   );

   // response side: random stalls plus one long hold-off counted here
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_done  = 1'b1;
         hold_left  = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   initial begin
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) begin
         @(posedge clock);
      end
      $display("timed out after %0d cycles", CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [15:0] pick_time_part(input int max_val);
      int v;
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5, 6: v = $urandom_range(max_val);
         7: v = $urandom_range(1) ? max_val + 1 : -1;
         8: v = int'($urandom_range(2 * max_val + 40)) - max_val - 20;
         default: v = $urandom;
      endcase
      return v[15:0];
   endfunction

   function automatic logic [31:0] pick_amount();
      int v;
      case ($urandom_range(7))
         0, 1: v = int'($urandom_range(200)) - 100;
         // whole days either way, plus a little
         2: v = (int'($urandom_range(48)) - 24) * 86400 + int'($urandom_range(4)) - 2;
         3: v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_request(input action_type act, input logic [15:0] h_in,
                               input logic [15:0] m_in, input logic [15:0] s_in,
                               input logic [31:0] amt);
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {amt, s_in, m_in, h_in};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      action_count[act]++;
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
   endtask

   // sender stops until every outstanding request has been answered
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic send_random_request();
      send_request(action_type'($urandom_range(3)), pick_time_part(23), pick_time_part(59),
                   pick_time_part(59), pick_amount());
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // boundaries, wrap in both directions, rejected sets, ignored fields
      send_request(ACT_CHECKED_SET, 23, 59, 59, 32'h1234_5678);
      send_request(ACT_SHIFT, -1, 99, 7, 1);
      send_request(ACT_SHIFT, 0, 0, 0, -1);
      send_request(ACT_CHECKED_SET, 24, 0, 0, 0);
      send_request(ACT_CHECKED_SET, 0, 60, 0, 0);
      send_request(ACT_CHECKED_SET, 0, 0, 60, 0);
      send_request(ACT_CHECKED_SET, -1, 0, 0, 0);
      send_request(ACT_CHECKED_SET, 0, 0, -1, 0);
      send_request(ACT_CHECKED_SET, -32768, -32768, -32768, 0);
      send_request(ACT_CHECKED_SET, 32767, 32767, 32767, 0);
      send_request(ACT_CHECKED_SET, 0, 0, 0, 32'hFFFF_FFFF);
      send_request(ACT_NORM_SET, -32768, -32768, -32768, 0);
      send_request(ACT_NORM_SET, 32767, 32767, 32767, 0);
      send_request(ACT_NORM_SET, -1, 0, 0, 0);
      send_request(ACT_NORM_SET, 24, 0, 0, 32'h8000_0000);
      send_request(ACT_SHIFT, 0, 0, 0, 32'h8000_0000);
      send_request(ACT_SHIFT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
      send_request(ACT_SHIFT, 0, 0, 0, -86400);
      send_request(ACT_CHECKED_SET, 12, 34, 56, 0);
      send_request(ACT_DIFF, 12, 34, 56, 0);
      send_request(ACT_DIFF, 0, 0, 0, 0);
      send_request(ACT_DIFF, -32768, -32768, -32768, 0);
      send_request(ACT_DIFF, 32767, 32767, 32767, 0);
      send_request(ACT_DIFF, 23, 59, 59, 32'h7FFF_FFFF);
      wait_for_responses();

      // back to back, with the long response hold-off part way through
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
         if (i == 60) begin
            hold_go = 1'b1;
         end
         send_random_request();
      end
      wait_for_responses();

      tx_idle_pct = 50;
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
         send_random_request();
      end
      wait_for_responses();

      tx_idle_pct  = 0;
      rx_stall_pct = 50;
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
         send_random_request();
      end
      wait_for_responses();

      tx_idle_pct  = 30;
      rx_stall_pct = 30;
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
         send_random_request();
      end
      wait_for_responses();

      // let any stray response show up
      rx_stall_pct = 0;
      repeat (16) @(negedge clock);

      $display("requests: %0d checked set, %0d normalised set, %0d shift, %0d difference",
               action_count[ACT_CHECKED_SET], action_count[ACT_NORM_SET],
               action_count[ACT_SHIFT], action_count[ACT_DIFF]);
      $display("traffic: back to back, sender gaps, response stalls, both, and a %0d-cycle hold-off",
               HOLD_CYCLES);
      if (fail_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d failures, %0d responses missing", fail_count, pending_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
